/* design/lru_frame_replacer_defines.svh */
// Assertion macros shared by the lru_frame_replacer checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LRU_FRAME_REPLACER_DEFINES_SVH
`define LRU_FRAME_REPLACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lfr_pkg.sv */
// Package for the LRU frame replacer: field widths, reset constants, op codes.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package lfr_pkg;

    localparam int ID_W           = 6;   // frame id field
    localparam int COUNT_W        = 7;   // count result field
    localparam int CAP_W          = 7;   // capacity register
    localparam int NUM_FRAMES_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_PIN    = 2'd1,
        OP_UNPIN  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

`default_nettype wire

/* design/lru_frame_replacer.sv */
// LRU frame replacer: chain of id cells with parallel compare, oldest in cell 0.
// Depends on lfr_pkg (widths, op codes, reset constants).
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-------------------------
//   request  | op, frame_num                          | start & !busy at clk edge
//   result   | ok, victim_frame, count                | done, one cycle, no stall
//   config   | cfg_wdata (capacity)                   | cfg_we at clk edge
//
// Throughput is one item per cycle; each request passes the request register,
// then one compare/shift pass across all cells into the result register.
// busy never rises: no item's pass holds up the next request.
// rst_n clears the request/result valids, the count, the cell valid vector and
// sets capacity to 64; cell ids are not reset (read only from valid cells).
// The receiver cannot stall: done pulses for exactly one cycle per item.
`default_nettype none

module lru_frame_replacer
    import lfr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         op,
    input  wire logic [ID_W-1:0]    frame_num,
    input  wire logic               cfg_we,
    input  wire logic [CAP_W-1:0]   cfg_wdata,
    output logic                    done,
    output logic                    ok,
    output logic [ID_W-1:0]         victim_frame,
    output logic [COUNT_W-1:0]      count
);

    // Count must hold NUM_FRAMES itself; compares run at the wider of it and capacity.
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Request register
    logic             in_valid_reg;
    op_t              op_reg;
    logic [ID_W-1:0]  fid_reg;

    // Cell chain and bookkeeping. valid_reg is a thermometer: cells 0..cnt-1.
    logic [ID_W-1:0]       cell_id_reg  [NUM_FRAMES];
    logic [ID_W-1:0]       cell_id_next [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [NUM_FRAMES-1:0] valid_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CAP_W-1:0]      cap_reg;

    // Result register
    logic                  done_reg;
    logic                  ok_reg;
    logic [ID_W-1:0]       victim_reg;
    logic [COUNT_W-1:0]    count_reg;

    // Per-cell compare and "at or after the hit" mask
    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] at_or_after;
    logic [NUM_FRAMES-1:0] shift_mask;
    logic                  hit;
    logic                  room;
    logic                  do_victim;
    logic                  do_pin;
    logic                  do_unpin;

    assign busy = 1'b0;

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match[i] = valid_reg[i] && (cell_id_reg[i] == fid_reg);
        end
    end

    // Ids are unique in the chain, so at most one match bit is set.
    always_comb
    begin
        at_or_after[0] = match[0];
        for (int i = 1; i < NUM_FRAMES; i++)
        begin
            at_or_after[i] = at_or_after[i-1] | match[i];
        end
    end

    assign hit  = |match;
    assign room = (CMP_W'(cnt_reg) < CMP_W'(cap_reg)) &&
                  (cnt_reg < CNT_W'(NUM_FRAMES));

    assign do_victim = in_valid_reg && (op_reg == OP_VICTIM) && (cnt_reg != '0);
    assign do_pin    = in_valid_reg && (op_reg == OP_PIN) && hit;
    assign do_unpin  = in_valid_reg && (op_reg == OP_UNPIN) && !hit && room;

    // Removal shifts every cell from the removed one upward down by one.
    assign shift_mask = {NUM_FRAMES{do_victim}} | ({NUM_FRAMES{do_pin}} & at_or_after);

    genvar g;
    generate
        for (g = 0; g < NUM_FRAMES; g++)
        begin : g_cell
            logic [ID_W-1:0] upper_id;
            if (g < NUM_FRAMES - 1)
            begin : g_mid
                assign upper_id = cell_id_reg[g+1];
            end
            else
            begin : g_top
                // Top cell drops out of the valid range on removal; keep it.
                assign upper_id = cell_id_reg[g];
            end

            always_comb
            begin
                if (shift_mask[g])
                begin
                    cell_id_next[g] = upper_id;
                end
                else if (do_unpin && (cnt_reg == CNT_W'(g)))
                begin
                    cell_id_next[g] = fid_reg;   // newest goes right after the tail
                end
                else
                begin
                    cell_id_next[g] = cell_id_reg[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (do_victim || do_pin)
        begin
            valid_next = valid_reg >> 1;
            cnt_next   = cnt_reg - CNT_W'(1);
        end
        else if (do_unpin)
        begin
            valid_next = {valid_reg[NUM_FRAMES-2:0], 1'b1};
            cnt_next   = cnt_reg + CNT_W'(1);
        end
    end

    // Cell ids: payload, no reset
    always_ff @(posedge clk)
    begin
        cell_id_reg <= cell_id_next;
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= op_t'(op);
            fid_reg <= frame_num;
        end
        victim_reg <= do_victim ? cell_id_reg[0] : '0;
        count_reg  <= COUNT_W'(cnt_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            cap_reg      <= CAP_RESET;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
            ok_reg       <= do_victim;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign victim_frame = victim_reg;
    assign count        = count_reg;

endmodule

`default_nettype wire

/* design/lfr_checker.sv */
// Port-level checker for lru_frame_replacer, attached by bind at the end.
// Depends on lfr_pkg and lru_frame_replacer_defines.svh.
`default_nettype none

`include "lru_frame_replacer_defines.svh"

module lfr_checker
    import lfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [1:0]         op,
    input  wire logic               done,
    input  wire logic               ok,
    input  wire logic [ID_W-1:0]    victim_frame,
    input  wire logic [COUNT_W-1:0] count
);

    logic acc;
    assign acc = start && !busy;

    // Every accepted item gives exactly one result, through the request and result registers.
    `LFR_ASSERT_IMP(a_result_follows, clk, rst_n, $past(rst_n, 2) && $past(rst_n) && $past(acc, 2), done, "accepted item produced no result")
    `LFR_ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(acc, 2), "result without an accepted item")
    // Only a victim request can evict.
    `LFR_ASSERT_IMP(a_ok_victim, clk, rst_n, done && ok, $past(op, 2) == OP_VICTIM, "eviction reported for a non-victim op")
    // After a non-eviction result, a back-to-back result moves the count by at most one.
    `LFR_ASSERT_NXT(a_count_step, clk, rst_n, done && !ok && (victim_frame == '0), !done || (count == $past(count)) || (count == $past(count) + COUNT_W'(1)) || (count + COUNT_W'(1) == $past(count)), "count jumped by more than one")

endmodule

bind lru_frame_replacer lfr_checker u_lfr_checker (.*);

`default_nettype wire
